/* sv/ckstk_pkg.sv */
`timescale 1ns / 1ps

package ckstk_pkg;

	localparam int STACK_DEPTH_DEF = 256;
	localparam int WORD_W          = 32;
	localparam int COUNT_W         = 9;

	localparam logic [1:0] OP_PUSH  = 2'd0;
	localparam logic [1:0] OP_POP   = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_WRITE = 2'd3;

	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_INDEX     = 2'd1;
	localparam logic [1:0] ERR_OVERFLOW  = 2'd2;
	localparam logic [1:0] ERR_UNDERFLOW = 2'd3;

	typedef struct packed {
		logic [1:0]               operation;
		logic signed [WORD_W-1:0] value;
		logic signed [WORD_W-1:0] index;
	} req_item_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] read_data;
		logic [1:0]               error_code;
		logic                     halted;
		logic [COUNT_W-1:0]       count;
	} rsp_item_t;

	// Access request from the control logic to the stack memory.
	typedef struct packed {
		logic              en;
		logic              we;
		logic [WORD_W-1:0] wdata;
	} mem_cmd_t;

endpackage

/* sv/ckstk_mem.sv */
`timescale 1ns / 1ps

module ckstk_mem #(
	parameter int DEPTH = ckstk_pkg::STACK_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                           clk,
	input  ckstk_pkg::mem_cmd_t            cmd,
	input  logic [AW-1:0]                  addr,
	output logic [ckstk_pkg::WORD_W-1:0]   rdata
);
	import ckstk_pkg::*;

	logic [WORD_W-1:0] store_q [DEPTH];
	logic [WORD_W-1:0] rdata_q;

	// Single port: one write or one registered read per cycle.
	always_ff @(posedge clk) begin
		if (cmd.en) begin
			if (cmd.we) begin
				store_q[addr] <= cmd.wdata;
			end else begin
				rdata_q <= store_q[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

/* sv/checked_stack_with_fault_halt_unit.sv */
`timescale 1ns / 1ps

// Bounded word stack with checked accesses and a sticky fault halt. Each request
// item pushes, pops, reads at an index or writes at an index (0 is the bottom);
// exactly one response item comes back per request, in order. A push onto a full
// stack, a pop from an empty one, or an index outside 0 .. count-1 is fatal: the
// response carries the error code, halted goes high and stays high, and every
// later request is answered with read_data 0, no error and the frozen count,
// without touching the stack. Throughput is one item per cycle while the response
// side does not stall: the stack words live in a single-port synchronous memory and
// each item makes at most one access to it, while count and halt live in flops and
// are updated at accept, so the next item sees them at once. The memory read is
// issued at the accepting edge, with the item held in stage 1; response valid rises
// when stage 1 advances into the response register. The stack memory is not cleared
// at reset; only entries below count are ever read.
module checked_stack_with_fault_halt_unit #(
	parameter int STACK_DEPTH = ckstk_pkg::STACK_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  ckstk_pkg::req_item_t req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output ckstk_pkg::rsp_item_t rsp
);
	import ckstk_pkg::*;

	localparam int AW    = $clog2(STACK_DEPTH);
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);

	logic [CNT_W-1:0]  count_q;
	logic              halt_q;

	logic              accept;
	logic              advance;
	logic [1:0]        err;
	logic              rd_hit;
	logic [CNT_W-1:0]  count_nxt;
	logic [AW-1:0]     addr;
	logic              idx_bad;
	mem_cmd_t          cmd;
	logic [WORD_W-1:0] rdata;

	// Stage 1: item that has made its memory access, waiting on read data.
	logic              valid_s1;
	logic              rd_s1;
	logic [1:0]        err_s1;
	logic              halted_s1;
	logic [COUNT_W-1:0] count_s1;

	logic              rsp_valid_q;
	rsp_item_t         rsp_q;

	// Stage 1 moves on whenever the response register is empty or draining.
	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;
	assign accept    = req_valid && !req_stall;

	// An unsigned compare catches negative indexes as well: they are at least 2^31.
	assign idx_bad = $unsigned(req.index) >= 32'(count_q);

	always_comb begin
		err       = ERR_NONE;
		rd_hit    = 1'b0;
		count_nxt = count_q;
		addr      = req.index[AW-1:0];
		cmd.en    = 1'b0;
		cmd.we    = 1'b0;
		cmd.wdata = req.value;
		if (!halt_q) begin
			unique case (req.operation)
				OP_PUSH: begin
					addr = count_q[AW-1:0];
					if (count_q >= CNT_W'(STACK_DEPTH)) begin
						err = ERR_OVERFLOW;
					end else begin
						cmd.en    = 1'b1;
						cmd.we    = 1'b1;
						count_nxt = count_q + 1'b1;
					end
				end
				OP_POP: begin
					count_nxt = count_q - 1'b1;
					addr      = count_nxt[AW-1:0];
					if (count_q == '0) begin
						err       = ERR_UNDERFLOW;
						count_nxt = count_q;
					end else begin
						cmd.en = 1'b1;
						rd_hit = 1'b1;
					end
				end
				OP_READ: begin
					if (idx_bad) begin
						err = ERR_INDEX;
					end else begin
						cmd.en = 1'b1;
						rd_hit = 1'b1;
					end
				end
				OP_WRITE: begin
					if (idx_bad) begin
						err = ERR_INDEX;
					end else begin
						cmd.en = 1'b1;
						cmd.we = 1'b1;
					end
				end
				default: begin
					err = ERR_NONE;
				end
			endcase
		end
		// Drop the memory access unless the item is actually taken.
		cmd.en = cmd.en && accept;
	end

	ckstk_mem #(
		.DEPTH(STACK_DEPTH),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.cmd  (cmd),
		.addr (addr),
		.rdata(rdata)
	);

	// Control state: count, halt and the valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			halt_q      <= 1'b0;
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_nxt;
				halt_q  <= halt_q || (err != ERR_NONE);
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: capture stage 1 on accept, the response on advance.
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1     <= rd_hit;
			err_s1    <= err;
			halted_s1 <= halt_q || (err != ERR_NONE);
			count_s1  <= COUNT_W'(count_nxt);
		end
		if (advance) begin
			rsp_q.read_data  <= rd_s1 ? $signed(rdata) : '0;
			rsp_q.error_code <= err_s1;
			rsp_q.halted     <= halted_s1;
			rsp_q.count      <= count_s1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* sv/ckstk_checker.sv */
`timescale 1ns / 1ps

module ckstk_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 req_valid,
	input logic                 req_stall,
	input ckstk_pkg::req_item_t req,
	input logic                 rsp_valid,
	input logic                 rsp_stall,
	input ckstk_pkg::rsp_item_t rsp
);
	import ckstk_pkg::*;

	logic rsp_take;
	logic seen_halt_q;

	assign rsp_take = rsp_valid && !rsp_stall;

	// Remember that a halted response has gone out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_halt_q <= 1'b0;
		end else if (rsp_take && rsp.halted) begin
			seen_halt_q <= 1'b1;
		end
	end

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_take && seen_halt_q |-> rsp.halted)
		else $error("halted dropped after a fault");

	a_err_halts: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_take && rsp.error_code != ERR_NONE |-> rsp.halted)
		else $error("error response without halt");

	a_err_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_take && (rsp.error_code != ERR_NONE || seen_halt_q) |-> rsp.read_data == '0)
		else $error("nonzero data on faulted or ignored item");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

endmodule

bind checked_stack_with_fault_halt_unit ckstk_checker u_ckstk_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_stall(req_stall),
	.req      (req),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp      (rsp)
);

/* bench/stack_check_pkg.sv */
`timescale 1ns / 1ps

package stack_check_pkg;

	import ckstk_pkg::*;

	class stack_shadow;

		logic signed [WORD_W-1:0] words [STACK_DEPTH_DEF];
		logic [COUNT_W-1:0]       depth;
		logic                     halted;
		rsp_item_t                expected_rsp_q[$];
		int                       mismatches;

		function new();
			depth = '0;
			halted = 1'b0;
			mismatches = 0;
		endfunction

		// Apply one accepted request to the shadow stack and queue its response.
		function void note_request(req_item_t r);
			rsp_item_t e;
			logic [WORD_W-1:0] ix;
			e = '0;
			ix = r.index;
			if (!halted) begin
				case (r.operation)
					OP_PUSH: begin
						if (depth >= STACK_DEPTH_DEF) begin
							e.error_code = ERR_OVERFLOW;
						end else begin
							words[depth] = r.value;
							depth = depth + 1'b1;
						end
					end
					OP_POP: begin
						if (depth == '0) begin
							e.error_code = ERR_UNDERFLOW;
						end else begin
							depth = depth - 1'b1;
							e.read_data = words[depth];
						end
					end
					OP_READ: begin
						if (ix >= depth) e.error_code = ERR_INDEX;
						else e.read_data = words[ix];
					end
					default: begin
						if (ix >= depth) e.error_code = ERR_INDEX;
						else words[ix] = r.value;
					end
				endcase
				if (e.error_code != ERR_NONE) begin
					halted = 1'b1;
					e.read_data = '0;
				end
			end
			e.halted = halted;
			e.count = depth;
			expected_rsp_q.push_back(e);
		endfunction

		function void report(string field, logic [WORD_W-1:0] exp_v, logic [WORD_W-1:0] act_v);
			mismatches++;
			$display("%0t: %s mismatch, expected %h, got %h", $time, field, exp_v, act_v);
		endfunction

		// Compare one accepted response with the oldest expected one.
		function void check_response(rsp_item_t a);
			rsp_item_t e;
			if (expected_rsp_q.size() == 0) begin
				mismatches++;
				$display("%0t: response with none expected, expected nothing, got %h", $time, a);
				return;
			end
			e = expected_rsp_q.pop_front();
			if (a.read_data !== e.read_data) report("read_data", e.read_data, a.read_data);
			if (a.error_code !== e.error_code) report("error_code", e.error_code, a.error_code);
			if (a.halted !== e.halted) report("halted", e.halted, a.halted);
			if (a.count !== e.count) report("count", e.count, a.count);
		endfunction

		function int pending();
			return expected_rsp_q.size();
		endfunction

	endclass

endpackage

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

	import ckstk_pkg::*;
	import stack_check_pkg::*;

	typedef enum {WALK_FILL, WALK_DRAIN, WALK_MIX} walk_mode_t;

	localparam int HOLDOFF_CYCLES = 80;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_item_t req = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_item_t rsp;

	// Idle and stall odds in percent, changed by the stimulus between phases.
	int send_idle_pct = 0;
	int rsp_stall_pct = 0;
	// Request for one long receiver hold-off: the stimulus toggles it, the
	// receiver process notes each toggle.
	logic holdoff_req = 1'b0;
	logic holdoff_ack = 1'b0;
	int   holdoff_left = 0;

	// Stack depth as the stimulus sees it; every item sent is accepted in order.
	int gen_depth = 0;

	stack_shadow shadow = new();

	checked_stack_with_fault_halt_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Hard limit: far above the slowest correct run.
	initial begin
		#2_000_000;
		$display("** checked_stack_with_fault_halt_unit: FAILED **");
		$finish;
	end

	// Watch both channels at the edge; values read here are the pre-edge ones.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) shadow.note_request(req);
			if (rsp_valid && !rsp_stall) shadow.check_response(rsp);
		end
	end

	// Receiver: random stall, or a long hold-off counted down here so that
	// the block backs up and stalls its request side.
	always @(posedge clk) begin
		if (holdoff_left > 0) begin
			rsp_stall <= 1'b1;
			holdoff_left <= holdoff_left - 1;
		end else if (holdoff_req != holdoff_ack) begin
			holdoff_ack <= holdoff_req;
			holdoff_left <= HOLDOFF_CYCLES;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
		end
	end

	// Favor the edges of the word range so sign and carry bits get hit often.
	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic req_item_t make_item(logic [1:0] op, logic [WORD_W-1:0] val,
			logic [WORD_W-1:0] idx);
		req_item_t r;
		r.operation = op;
		r.value = val;
		r.index = idx;
		return r;
	endfunction

	// Build a request that cannot fault at the current depth.
	function automatic req_item_t legal_item(int pct_push, int pct_pop);
		logic [1:0] op;
		int roll;
		logic [WORD_W-1:0] idx;
		roll = $urandom_range(0, 99);
		if (roll < pct_push) op = OP_PUSH;
		else if (roll < pct_push + pct_pop) op = OP_POP;
		else op = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
		if (op == OP_PUSH && gen_depth == STACK_DEPTH_DEF) op = OP_POP;
		if (op != OP_PUSH && gen_depth == 0) op = OP_PUSH;
		// Index is unused by push and pop: let all of its bits toggle there.
		idx = $urandom;
		if (op == OP_READ || op == OP_WRITE) begin
			case ($urandom_range(0, 3))
				0: idx = 0;
				1: idx = gen_depth - 1;
				default: idx = $urandom_range(0, gen_depth - 1);
			endcase
		end
		return make_item(op, pick_word(), idx);
	endfunction

	// Offer one item, idling first at the current odds, and hold it until taken.
	// Valid is left high afterward so back-to-back items need no reassertion.
	task automatic send_item(input req_item_t it);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req <= it;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		// Track depth for items that do not fault.
		if (it.operation == OP_PUSH && gen_depth < STACK_DEPTH_DEF) gen_depth++;
		else if (it.operation == OP_POP && gen_depth > 0) gen_depth--;
	endtask

	task automatic set_idling(int phase);
		case (phase)
			0: begin send_idle_pct <= 0;  rsp_stall_pct <= 0;  end
			1: begin send_idle_pct <= 72; rsp_stall_pct <= 0;  end
			2: begin send_idle_pct <= 0;  rsp_stall_pct <= 72; end
			default: begin send_idle_pct <= 14; rsp_stall_pct <= 14; end
		endcase
	endtask

	// End on one fatal fault chosen at random, then check that later items
	// are ignored with the halt held and the count frozen.
	task automatic fault_and_ignore();
		logic [1:0] op;
		logic [WORD_W-1:0] idx;
		case ($urandom_range(0, 3))
			0: begin
				// Overflow: fill to the top, then push once more.
				while (gen_depth < STACK_DEPTH_DEF) send_item(legal_item(100, 0));
				send_item(make_item(OP_PUSH, pick_word(), $urandom));
			end
			1: begin
				// Underflow: drain to empty, then pop once more.
				while (gen_depth > 0) send_item(legal_item(0, 100));
				send_item(make_item(OP_POP, pick_word(), $urandom));
			end
			2: begin
				// Negative index.
				op = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
				send_item(make_item(op, pick_word(), {1'b1, 31'($urandom)}));
			end
			default: begin
				// Index at or beyond the count.
				op = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
				idx = $urandom_range(0, 1) ? gen_depth : 32'h7FFF_FFFF;
				send_item(make_item(op, pick_word(), idx));
			end
		endcase
		repeat (24) begin
			case ($urandom_range(0, 3))
				0: idx = '1;
				1: idx = 32'h7FFF_FFFF;
				2: idx = '0;
				default: idx = $urandom;
			endcase
			op = 2'($urandom_range(0, 3));
			send_item(make_item(op, pick_word(), idx));
		end
	endtask

	initial begin
		walk_mode_t mode;
		int mix_left;
		int pct_push;
		int pct_pop;

		// Hold reset, then release it at an edge.
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: word extremes, every operation, bottom and top indexes.
		set_idling(0);
		send_item(make_item(OP_PUSH, 32'h8000_0000, 0));
		send_item(make_item(OP_PUSH, 32'h7FFF_FFFF, 0));
		send_item(make_item(OP_PUSH, 32'h0000_0000, 0));
		send_item(make_item(OP_PUSH, 32'hFFFF_FFFF, 0));
		send_item(make_item(OP_PUSH, 32'h5555_5555, 0));
		send_item(make_item(OP_READ, 0, 0));
		send_item(make_item(OP_READ, 0, 4));
		send_item(make_item(OP_READ, 0, 2));
		send_item(make_item(OP_WRITE, 32'hAAAA_AAAA, 0));
		send_item(make_item(OP_WRITE, 32'h1234_5678, 4));
		send_item(make_item(OP_READ, 0, 0));
		send_item(make_item(OP_READ, 0, 4));
		repeat (5) send_item(make_item(OP_POP, 0, 0));
		send_item(make_item(OP_PUSH, 32'h0000_0001, 0));
		send_item(make_item(OP_READ, 0, 0));
		send_item(make_item(OP_WRITE, 32'h7FFF_FFFF, 0));
		send_item(make_item(OP_POP, 0, 0));

		// Random walk: fill to the top, drain to empty, wander, repeat.
		mode = WALK_FILL;
		mix_left = 0;
		for (int n = 0; n < 1950; n++) begin
			if (n % 150 == 0) begin
				set_idling((n / 150) % 4);
				// Start a long hold-off while the sender runs flat out.
				if ((n / 150) % 4 == 0 && (n == 0 || n == 600)) holdoff_req <= !holdoff_req;
			end
			case (mode)
				WALK_FILL: if (gen_depth == STACK_DEPTH_DEF) mode = WALK_DRAIN;
				WALK_DRAIN: begin
					if (gen_depth == 0) begin
						mode = WALK_MIX;
						mix_left = $urandom_range(40, 200);
					end
				end
				default: begin
					if (mix_left == 0) mode = WALK_FILL;
					else mix_left--;
				end
			endcase
			case (mode)
				WALK_FILL:  begin pct_push = 85; pct_pop = 5;  end
				WALK_DRAIN: begin pct_push = 5;  pct_pop = 85; end
				default:    begin pct_push = 35; pct_pop = 30; end
			endcase
			send_item(legal_item(pct_push, pct_pop));
		end

		set_idling(3);
		fault_and_ignore();
		req_valid <= 1'b0;

		// Drain outstanding responses, then allow for stray late ones.
		while (shadow.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		if (shadow.mismatches == 0 && shadow.pending() == 0) begin
			$display("** checked_stack_with_fault_halt_unit: PASSED **");
		end else begin
			$display("** checked_stack_with_fault_halt_unit: FAILED **");
		end
		$finish;
	end

endmodule

/* sim.f */
sv/ckstk_pkg.sv
sv/ckstk_mem.sv
sv/checked_stack_with_fault_halt_unit.sv
sv/ckstk_checker.sv
bench/stack_check_pkg.sv
bench/tb_top.sv
